// File: design/srfp_pkg.sv
// ============================================================================
// srfp_pkg
// Shared types and constants for the sensor reply frame parser.
// ============================================================================
package srfp_pkg;

    // Frame delimiters and the command code of a reply frame
    localparam logic [7:0] HEAD_BYTE = 8'hAA;
    localparam logic [7:0] TAIL_BYTE = 8'hAB;
    localparam logic [7:0] REPLY_CMD = 8'hC5;

    // Frame geometry: ten bytes, the head is byte 0 and the tail byte 9
    localparam int FRAME_LEN = 10;
    // Bytes 0..8 are kept in the cell row; the tail is checked on the fly
    localparam int CHAIN_LEN = FRAME_LEN - 1;

    typedef logic [3:0] t_pos;
    typedef logic [7:0] t_byte;

    localparam t_pos POS_HUNT      = 4'd0;
    localparam t_pos POS_FIRST     = 4'd1;
    localparam t_pos SUM_FIRST_POS = 4'd2;
    localparam t_pos SUM_LAST_POS  = 4'd7;
    localparam t_pos POS_LAST      = 4'(FRAME_LEN - 1);

    // Result kinds
    typedef enum logic [1:0] {
        KIND_DATA  = 2'd0,
        KIND_REPLY = 2'd1,
        KIND_ERROR = 2'd2
    } t_frame_kind;

    // Place of frame byte j in the cell row once byte 8 has been shifted in
    function automatic t_pos cell_of(input int j);
        return t_pos'(CHAIN_LEN - 1 - j);
    endfunction

endpackage

// File: design/srfp_in_if.sv
// ============================================================================
// srfp_in_if
// Byte input channel: valid/ready handshake carrying one received byte.
// ============================================================================
interface srfp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// File: design/srfp_out_if.sv
// ============================================================================
// srfp_out_if
// Result channel: valid/ready handshake carrying one decoded frame result.
// ============================================================================
interface srfp_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  frame_kind;
    logic [15:0] fine_dust_tenths;
    logic [15:0] coarse_dust_tenths;
    logic [7:0]  reply_kind;
    logic [7:0]  reply_arg_a;
    logic [7:0]  reply_arg_b;

    modport source (
        output valid, output frame_kind, output fine_dust_tenths,
        output coarse_dust_tenths, output reply_kind, output reply_arg_a,
        output reply_arg_b, input ready
    );
    modport sink (
        input valid, input frame_kind, input fine_dust_tenths,
        input coarse_dust_tenths, input reply_kind, input reply_arg_a,
        input reply_arg_b, output ready
    );
endinterface

// File: design/srfp_cell.sv
// ============================================================================
// srfp_cell
// One byte cell of the frame shift row; takes its left neighbor's byte
// on every shift.
// ============================================================================
module srfp_cell (
    input  logic           i_clk,
    input  logic           i_shift,
    input  srfp_pkg::t_byte i_byte,
    output srfp_pkg::t_byte o_byte
);

    srfp_pkg::t_byte r_byte;
    srfp_pkg::t_byte n_byte;

    // hold unless the row moves
    always_comb begin
        n_byte = i_shift ? i_byte : r_byte;
    end

    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
    end

    assign o_byte = r_byte;

endmodule

// File: design/sensor_reply_frame_parser.sv
// ============================================================================
// sensor_reply_frame_parser
// Hunts for 10-byte sensor frames in a received byte stream and decodes
// data, command reply and checksum error results.
// ============================================================================
// The parser takes one byte per clock cycle, with no gaps needed between
// bytes, as long as the result register is empty or its result is taken in
// the same cycle. Frame bytes 0..8 shift through a row of nine byte cells
// while a running sum covers bytes 2..7; when the tail byte arrives the
// result is decided in that same cycle and is registered for the result
// channel. Bytes outside a frame are dropped; a frame with a wrong tail
// is dropped without a result and hunting restarts at the next byte.
module sensor_reply_frame_parser (
    input  logic             i_clk,
    input  logic             i_rst_n,
    srfp_in_if.sink          i_rx,
    srfp_out_if.source       o_res
);

    // ------------------------------------------------------------------
    // Input transfer and frame position
    // ------------------------------------------------------------------
    logic                w_accept;
    logic                w_is_head;
    logic                w_is_tail;
    logic                w_in_sum;
    logic                w_shift;
    logic                w_load;
    srfp_pkg::t_pos      r_pos;
    srfp_pkg::t_pos      n_pos;
    srfp_pkg::t_byte     r_sum;
    srfp_pkg::t_byte     n_sum;

    assign i_rx.ready = !o_res.valid || o_res.ready;
    assign w_accept   = i_rx.valid && i_rx.ready;
    assign w_is_head  = (i_rx.rx_byte == srfp_pkg::HEAD_BYTE);
    assign w_is_tail  = (i_rx.rx_byte == srfp_pkg::TAIL_BYTE);
    assign w_in_sum   = (r_pos >= srfp_pkg::SUM_FIRST_POS) &&
                        (r_pos <= srfp_pkg::SUM_LAST_POS);
    assign w_shift    = w_accept && ((r_pos != srfp_pkg::POS_HUNT) || w_is_head);
    assign w_load     = w_accept && (r_pos == srfp_pkg::POS_LAST) && w_is_tail;

    // next position and checksum
    always_comb begin
        n_pos = r_pos;
        n_sum = r_sum;
        if (w_accept) begin
            priority if (r_pos == srfp_pkg::POS_HUNT) begin
                n_pos = w_is_head ? srfp_pkg::POS_FIRST : srfp_pkg::POS_HUNT;
                n_sum = '0;
            end else if (r_pos < srfp_pkg::POS_LAST) begin
                n_pos = r_pos + srfp_pkg::t_pos'(1);
                if (w_in_sum) begin
                    n_sum = r_sum + i_rx.rx_byte;
                end
            end else begin
                // end of frame, or an out-of-range position: back to hunting
                n_pos = srfp_pkg::POS_HUNT;
                n_sum = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= srfp_pkg::POS_HUNT;
            r_sum <= '0;
        end else begin
            r_pos <= n_pos;
            r_sum <= n_sum;
        end
    end

    // ------------------------------------------------------------------
    // Row of byte cells: cell 0 takes the received byte
    // ------------------------------------------------------------------
    srfp_pkg::t_byte w_cell [srfp_pkg::CHAIN_LEN];

    for (genvar g = 0; g < srfp_pkg::CHAIN_LEN; g++) begin : g_cell
        srfp_pkg::t_byte w_left;
        if (g == 0) begin : g_head
            assign w_left = i_rx.rx_byte;
        end else begin : g_body
            assign w_left = w_cell[g-1];
        end
        srfp_cell u_cell (
            .i_clk   (i_clk),
            .i_shift (w_shift),
            .i_byte  (w_left),
            .o_byte  (w_cell[g])
        );
    end

    // ------------------------------------------------------------------
    // Frame decode, valid only while the tail byte is on the input
    // ------------------------------------------------------------------
    srfp_pkg::t_byte      w_cmd;
    srfp_pkg::t_byte      w_b2;
    srfp_pkg::t_byte      w_b3;
    srfp_pkg::t_byte      w_b4;
    srfp_pkg::t_byte      w_b5;
    srfp_pkg::t_byte      w_check;
    srfp_pkg::t_frame_kind w_kind;

    assign w_cmd   = w_cell[srfp_pkg::cell_of(1)];
    assign w_b2    = w_cell[srfp_pkg::cell_of(2)];
    assign w_b3    = w_cell[srfp_pkg::cell_of(3)];
    assign w_b4    = w_cell[srfp_pkg::cell_of(4)];
    assign w_b5    = w_cell[srfp_pkg::cell_of(5)];
    assign w_check = w_cell[srfp_pkg::cell_of(8)];

    always_comb begin
        priority if (r_sum != w_check) begin
            w_kind = srfp_pkg::KIND_ERROR;
        end else if (w_cmd == srfp_pkg::REPLY_CMD) begin
            w_kind = srfp_pkg::KIND_REPLY;
        end else begin
            w_kind = srfp_pkg::KIND_DATA;
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    logic                  r_valid;
    srfp_pkg::t_frame_kind r_kind;
    logic [15:0]           r_fine;
    logic [15:0]           r_coarse;
    srfp_pkg::t_byte       r_rkind;
    srfp_pkg::t_byte       r_arg_a;
    srfp_pkg::t_byte       r_arg_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_valid <= 1'b0;
        end
    end

    // payload: fields foreign to the kind read zero
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_kind   <= w_kind;
            r_fine   <= (w_kind == srfp_pkg::KIND_DATA)  ? {w_b3, w_b2} : 16'd0;
            r_coarse <= (w_kind == srfp_pkg::KIND_DATA)  ? {w_b5, w_b4} : 16'd0;
            r_rkind  <= (w_kind == srfp_pkg::KIND_REPLY) ? w_b2 : 8'd0;
            r_arg_a  <= (w_kind == srfp_pkg::KIND_REPLY) ? w_b3 : 8'd0;
            r_arg_b  <= (w_kind == srfp_pkg::KIND_REPLY) ? w_b4 : 8'd0;
        end
    end

    assign o_res.valid              = r_valid;
    assign o_res.frame_kind         = r_kind;
    assign o_res.fine_dust_tenths   = r_fine;
    assign o_res.coarse_dust_tenths = r_coarse;
    assign o_res.reply_kind         = r_rkind;
    assign o_res.reply_arg_a        = r_arg_a;
    assign o_res.reply_arg_b        = r_arg_b;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= srfp_pkg::POS_LAST)
        else $error("frame position beyond last byte");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.ready) |-> !w_accept)
        else $error("byte taken while a result is stalled");

    a_frame_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (r_pos == srfp_pkg::POS_LAST)) |=>
            (r_pos == srfp_pkg::POS_HUNT) && (r_sum == '0))
        else $error("parser did not return to hunting after a frame");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> o_res.valid)
        else $error("tail transfer produced no result");

endmodule

// File: tb/sv/tb_sensor_reply_frame_parser.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_sensor_reply_frame_parser
// Self-checking bench for the sensor reply frame parser. Byte transfers are
// fed through the input channel while a frame decoder kept inside the bench
// tracks head hunting, the byte gathering and the checksum, and queues the
// result each frame should give. Results taken from the output channel are
// checked field by field in order. A directed opening covers the special
// frames; the random part mixes well-formed frames with bad sums, bad tails,
// odd commands and line noise, under changing sender and receiver stalls.
// ============================================================================
module tb_sensor_reply_frame_parser;

    localparam int ITEMS_TARGET = 700;
    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 8;

    // One decoded frame as seen on the result channel
    typedef struct packed {
        srfp_pkg::t_frame_kind kind;
        logic [15:0]           fine;
        logic [15:0]           coarse;
        logic [7:0]            rep_kind;
        logic [7:0]            rep_a;
        logic [7:0]            rep_b;
    } t_frame_result;

    // ------------------------------------------------------------------------
    // Frame decoder and result scoreboard
    // ------------------------------------------------------------------------
    class t_frame_scoreboard;
        srfp_pkg::t_byte frame_bytes[srfp_pkg::FRAME_LEN];
        int              gather_pos;
        srfp_pkg::t_byte run_sum;
        t_frame_result   pending_results[$];
        int              mismatches;
        int              n_bytes_used;
        int              n_bytes_seen;
        int              n_dropped;
        int              n_kind[3];

        function new();
            clear_frame();
            mismatches   = 0;
            n_bytes_used = 0;
            n_bytes_seen = 0;
            n_dropped    = 0;
            n_kind       = '{0, 0, 0};
        endfunction

        function void clear_frame();
            foreach (frame_bytes[k]) frame_bytes[k] = 8'h00;
            gather_pos = 0;
            run_sum    = 8'h00;
        endfunction

        // Track one accepted byte; queue the result of a completed frame
        function void note_byte(srfp_pkg::t_byte b);
            t_frame_result r;
            n_bytes_seen++;
            // hunting: only a head byte opens a frame
            if (gather_pos == 0) begin
                if (b == srfp_pkg::HEAD_BYTE) begin
                    frame_bytes[0] = b;
                    gather_pos     = 1;
                    n_bytes_used++;
                end
                return;
            end
            n_bytes_used++;
            frame_bytes[gather_pos] = b;
            if (gather_pos >= 2 && gather_pos <= 7)
                run_sum = run_sum + b;
            if (gather_pos < srfp_pkg::FRAME_LEN - 1) begin
                gather_pos++;
                return;
            end
            // last byte: a bad tail drops the frame silently
            if (b != srfp_pkg::TAIL_BYTE) begin
                n_dropped++;
                clear_frame();
                return;
            end
            r = '0;
            if (run_sum != frame_bytes[8]) begin
                r.kind = srfp_pkg::KIND_ERROR;
            end else if (frame_bytes[1] == srfp_pkg::REPLY_CMD) begin
                r.kind     = srfp_pkg::KIND_REPLY;
                r.rep_kind = frame_bytes[2];
                r.rep_a    = frame_bytes[3];
                r.rep_b    = frame_bytes[4];
            end else begin
                r.kind   = srfp_pkg::KIND_DATA;
                r.fine   = {frame_bytes[3], frame_bytes[2]};
                r.coarse = {frame_bytes[5], frame_bytes[4]};
            end
            pending_results.push_back(r);
            clear_frame();
        endfunction

        task report(string msg);
            $display("%0t ns  mismatch: %s", $realtime, msg);
            mismatches++;
        endtask

        task check_field(string name, logic [15:0] got, logic [15:0] want);
            if (got !== want)
                report($sformatf("%s got 0x%h, expected 0x%h", name, got, want));
        endtask

        // Compare one accepted result with the oldest queued one
        task check_result(t_frame_result got);
            t_frame_result want;
            if (pending_results.size() == 0) begin
                report($sformatf("result kind %0d with no frame pending", got.kind));
                return;
            end
            want = pending_results.pop_front();
            check_field("frame_kind", 16'(got.kind), 16'(want.kind));
            check_field("fine_dust_tenths", got.fine, want.fine);
            check_field("coarse_dust_tenths", got.coarse, want.coarse);
            check_field("reply_kind", 16'(got.rep_kind), 16'(want.rep_kind));
            check_field("reply_arg_a", 16'(got.rep_a), 16'(want.rep_a));
            check_field("reply_arg_b", 16'(got.rep_b), 16'(want.rep_b));
            if (want.kind <= srfp_pkg::KIND_ERROR)
                n_kind[want.kind]++;
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;
    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    int   quiet_cycles   = 0;

    t_frame_scoreboard sb = new();

    srfp_in_if  rx_if ();
    srfp_out_if res_if ();

    sensor_reply_frame_parser u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_if),
        .o_res   (res_if)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Byte sender
    // ------------------------------------------------------------------------
    task automatic send_byte(input srfp_pkg::t_byte b);
        // random idle cycles ahead of the transfer
        while ($urandom_range(99) < send_idle_pct) begin
            rx_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        rx_if.valid   <= 1'b1;
        rx_if.rx_byte <= b;
        @(posedge i_clk);
        while (!rx_if.ready) @(posedge i_clk);
        sb.note_byte(b);
    endtask

    // Payload holds frame bytes 2..7, byte 2 in the low bits
    task automatic send_frame(input srfp_pkg::t_byte cmd, input logic [47:0] payload,
                              input bit bad_sum, input srfp_pkg::t_byte tail);
        srfp_pkg::t_byte sum = 8'h00;
        for (int k = 0; k < 6; k++) sum = sum + payload[8*k +: 8];
        if (bad_sum) sum = sum + srfp_pkg::t_byte'($urandom_range(1, 255));
        send_byte(srfp_pkg::HEAD_BYTE);
        send_byte(cmd);
        for (int k = 0; k < 6; k++) send_byte(payload[8*k +: 8]);
        send_byte(sum);
        send_byte(tail);
    endtask

    // Payload byte biased toward the extremes and the head value
    function automatic srfp_pkg::t_byte pick_byte();
        int sel = $urandom_range(15);
        if (sel < 2) return 8'h00;
        if (sel < 4) return 8'hFF;
        if (sel == 4) return srfp_pkg::HEAD_BYTE;
        return srfp_pkg::t_byte'($urandom_range(255));
    endfunction

    // ------------------------------------------------------------------------
    // Result receiver with random back-pressure
    // ------------------------------------------------------------------------
    initial begin
        t_frame_result seen;
        res_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && res_if.valid && res_if.ready) begin
                seen.kind     = srfp_pkg::t_frame_kind'(res_if.frame_kind);
                seen.fine     = res_if.fine_dust_tenths;
                seen.coarse   = res_if.coarse_dust_tenths;
                seen.rep_kind = res_if.reply_kind;
                seen.rep_a    = res_if.reply_arg_a;
                seen.rep_b    = res_if.reply_arg_b;
                sb.check_result(seen);
            end
            res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: too long without any transfer ends the run
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((rx_if.valid && rx_if.ready) || (res_if.valid && res_if.ready))
                quiet_cycles = 0;
            else
                quiet_cycles = quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                         STALL_LIMIT, sb.pending_results.size());
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        int              phase;
        int              pick;
        srfp_pkg::t_byte cmd;
        srfp_pkg::t_byte tail;
        logic [47:0]     payload;

        i_rst_n       <= 1'b0;
        rx_if.valid   <= 1'b0;
        rx_if.rx_byte <= 8'h00;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: noise while hunting, data frame with extreme readings and
        // a head value inside, reply frame, then a bad tail that is a head
        send_byte(8'h00);
        send_frame(8'h00, 48'h80_01_AA_00_FF_FF, 1'b0, srfp_pkg::TAIL_BYTE);
        send_frame(srfp_pkg::REPLY_CMD, 48'h00_FF_33_FF_80_00, 1'b0, srfp_pkg::TAIL_BYTE);
        send_frame(8'h12, 48'h01_23_45_67_89_AB, 1'b0, srfp_pkg::HEAD_BYTE);

        // random: mostly frames with random content, some broken ones
        while (sb.n_bytes_seen < ITEMS_TARGET) begin
            phase = sb.n_bytes_seen * 4 / ITEMS_TARGET;
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 57; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 57; end
                default: begin send_idle_pct = 14; recv_stall_pct = 14; end
            endcase
            pick = $urandom_range(99);
            if (pick < 78) begin
                case ($urandom_range(9))
                    0, 1, 2: cmd = srfp_pkg::REPLY_CMD;
                    3:       cmd = ($urandom_range(1) != 0) ? srfp_pkg::HEAD_BYTE
                                                            : srfp_pkg::TAIL_BYTE;
                    default: cmd = srfp_pkg::t_byte'($urandom_range(255));
                endcase
                for (int k = 0; k < 6; k++) payload[8*k +: 8] = pick_byte();
                tail = srfp_pkg::TAIL_BYTE;
                if ($urandom_range(9) == 0) begin
                    tail = ($urandom_range(2) == 0) ? srfp_pkg::HEAD_BYTE
                                                    : srfp_pkg::t_byte'($urandom_range(255));
                    if (tail == srfp_pkg::TAIL_BYTE) tail = 8'h00;
                end
                send_frame(cmd, payload, $urandom_range(6) == 0, tail);
            end else if (pick < 92) begin
                // line noise between frames
                repeat ($urandom_range(1, 5))
                    send_byte(srfp_pkg::t_byte'($urandom_range(255)));
            end else begin
                // truncated frame: a stray head swallows what follows
                send_byte(srfp_pkg::HEAD_BYTE);
                repeat ($urandom_range(1, 8)) send_byte(pick_byte());
            end
        end
        rx_if.valid <= 1'b0;

        // drain outstanding results, then let the pipeline settle
        while (sb.pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d bytes taken (%0d inside frames), %0d frames dropped on a bad tail",
                 sb.n_bytes_seen, sb.n_bytes_used, sb.n_dropped);
        $display("results checked: %0d data, %0d reply, %0d checksum error; %0d mismatches",
                 sb.n_kind[srfp_pkg::KIND_DATA], sb.n_kind[srfp_pkg::KIND_REPLY],
                 sb.n_kind[srfp_pkg::KIND_ERROR], sb.mismatches);
        if (sb.mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// File: files.f
design/srfp_pkg.sv
design/srfp_in_if.sv
design/srfp_out_if.sv
design/srfp_cell.sv
design/sensor_reply_frame_parser.sv
tb/sv/tb_sensor_reply_frame_parser.sv
